// ----- hdl/pjd_pkg.sv -----
// Shared types, constants and the job ordering function of the job dispatcher.
package pjd_pkg;

    localparam int PJD_QUEUE_DEPTH = 64;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_ASSIGN = 2'd1,
        FUNC_QUERY  = 2'd2
    } pjd_func_t;

    typedef struct packed {
        logic [30:0] job_time;
        logic [30:0] job_id;
        logic [15:0] importance;
        logic [30:0] duration;
    } pjd_job_t;

    // Controller to datapath.
    typedef struct packed {
        logic idle;
        logic scan;
        logic emit;
        logic shift;
    } pjd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic pop_go;
        logic pass_done;
        logic out_free;
        logic last_pop;
    } pjd_sts_t;

    // True when job a is strictly better than job b.
    function automatic logic job_better(pjd_job_t a, pjd_job_t b);
        logic res;
        if (a.importance != b.importance)
            res = a.importance > b.importance;
        else if (a.job_time != b.job_time)
            res = a.job_time < b.job_time;
        else
            res = a.duration < b.duration;
        return res;
    endfunction

endpackage

// ----- hdl/pjd_in_if.sv -----
// Input word channel of the job dispatcher.
interface pjd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [30:0] job_time;
    logic [30:0] job_id;
    logic [15:0] job_importance;
    logic [30:0] job_duration;
    logic [6:0]  request_count;

    modport source (output valid, func, job_time, job_id, job_importance, job_duration,
                    request_count, input ready);
    modport sink (input valid, func, job_time, job_id, job_importance, job_duration,
                  request_count, output ready);
endinterface

// ----- hdl/pjd_out_if.sv -----
// Output word channel of the job dispatcher.
interface pjd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] out_time;
    logic [30:0] out_id;
    logic [15:0] out_importance;
    logic [30:0] out_duration;
    logic        last_of_run;

    modport source (output valid, out_time, out_id, out_importance, out_duration,
                    last_of_run, input ready);
    modport sink (input valid, out_time, out_id, out_importance, out_duration,
                  last_of_run, output ready);
endinterface

// ----- hdl/priority_job_dispatcher.sv -----
// Top level of the priority job dispatcher: controller, datapath and checks.
// Push word, or a word that pops nothing: taken while idle; the block stays idle for the next word.
// Assign/query word popping n jobs from a store of T: each pop scans all T jobs for the best job,
// then loads the output (held while the output word waits), then compacts the store by moving
// each job behind the best one place forward.
// Reset (rst_n, async low) empties the store and zeroes the free-CPU count; RAM needs no clear.
module priority_job_dispatcher import pjd_pkg::*; #(
    parameter int QUEUE_DEPTH = PJD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    pjd_in_if.sink      in_job,
    pjd_out_if.source   out_job,
    input  logic        cpu_count_we,
    input  logic [15:0] cpu_count_data
);
    pjd_cmd_t cmd;
    pjd_sts_t sts;

    // Sequence each pop: scan for the best job, hand it to the output, compact the store.
    pjd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Hold the jobs, counters and output word.
    pjd_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_job         (in_job),
        .out_job        (out_job),
        .cpu_count_we   (cpu_count_we),
        .cpu_count_data (cpu_count_data),
        .cmd            (cmd),
        .sts            (sts)
    );

    // At most one phase of a pop is active at a time.
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.idle, cmd.scan, cmd.emit, cmd.shift}))
        else $error("more than one phase active");

    // Loading the output word always leaves a valid word on the next cycle.
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_job.valid)
        else $error("emitted job not presented");

    // No new word is taken while a pop run scans or compacts the store.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan || cmd.shift) |-> !in_job.ready)
        else $error("input taken during pop run");
endmodule

// ----- hdl/pjd_ram.sv -----
// Generic single write, single read RAM with registered read data.
module pjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/pjd_ctrl.sv -----
// Sequencing state machine of the job dispatcher.
module pjd_ctrl import pjd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  pjd_sts_t sts,
    output pjd_cmd_t cmd
);
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_SHIFT = 4'b1000
    } pjd_state_t;

    pjd_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (sts.pop_go) state_next = ST_SCAN;
            ST_SCAN:  if (sts.pass_done) state_next = ST_EMIT;
            ST_EMIT:  if (sts.out_free) state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                if (sts.pass_done)
                    state_next = sts.last_pop ? ST_IDLE : ST_SCAN;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd.idle  = (state_reg == ST_IDLE);
    assign cmd.scan  = (state_reg == ST_SCAN);
    assign cmd.emit  = (state_reg == ST_EMIT) && sts.out_free;
    assign cmd.shift = (state_reg == ST_SHIFT);
endmodule

// ----- hdl/pjd_dp.sv -----
// Job store, scan and compaction datapath with counters and output register.
module pjd_dp import pjd_pkg::*; #(
    parameter int QUEUE_DEPTH = PJD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    pjd_in_if.sink      in_job,
    pjd_out_if.source   out_job,
    input  logic        cpu_count_we,
    input  logic [15:0] cpu_count_data,
    input  pjd_cmd_t    cmd,
    output pjd_sts_t    sts
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] total_reg, total_next;
    logic [15:0]   free_reg, free_next;
    logic [CW-1:0] pop_left_reg, pop_left_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rvalid_reg, first_reg, first_next;
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] ridx_reg, best_idx_reg;
    pjd_job_t      best_reg, out_reg, rdata, push_job;
    logic          out_last_reg;

    logic          accept, push, pop_go, rd_issue, shift_we, take_new, finish;
    logic [16:0]   req_w, free_w, tot_w, n_w;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;

    assign accept = in_job.valid && cmd.idle;
    assign in_job.ready = cmd.idle;

    // Saturate the request at the queue depth and clamp it by stored jobs, and for an assign also by free CPUs.
    always_comb
    begin
        req_w  = 17'(in_job.request_count);
        if (req_w > 17'(QUEUE_DEPTH))
            req_w = 17'(QUEUE_DEPTH);
        free_w = {1'b0, free_reg};
        tot_w  = 17'(total_reg);
        n_w    = '0;
        case (in_job.func)
            FUNC_ASSIGN:
            begin
                n_w = (free_w < req_w) ? free_w : req_w;
                if (n_w > tot_w)
                    n_w = tot_w;
            end
            FUNC_QUERY: n_w = (req_w < tot_w) ? req_w : tot_w;
            default:    n_w = '0;
        endcase
    end

    assign push   = accept && (in_job.func == FUNC_PUSH) && (total_reg < CW'(QUEUE_DEPTH));
    assign pop_go = accept && (n_w != '0);

    assign rd_issue = (cmd.scan || cmd.shift) && (cnt_reg != total_reg);
    assign shift_we = cmd.shift && rvalid_reg;
    assign take_new = cmd.scan && rvalid_reg && (first_reg || job_better(rdata, best_reg));
    assign finish   = cmd.shift && sts.pass_done;

    assign push_job = '{job_time: in_job.job_time, job_id: in_job.job_id,
                        importance: in_job.job_importance, duration: in_job.job_duration};

    assign ram_we    = push || shift_we;
    assign ram_waddr = push ? total_reg[AW-1:0] : AW'(ridx_reg - 1'b1);

    pjd_ram #(.WIDTH($bits(pjd_job_t)), .DEPTH(QUEUE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push ? push_job : rdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (pop_go || finish)
            cnt_next = '0;
        else if (cmd.emit)
            cnt_next = CW'(best_idx_reg) + 1'b1;
        else if (rd_issue)
            cnt_next = cnt_reg + 1'b1;

        first_next = first_reg;
        if (pop_go || finish)
            first_next = 1'b1;
        else if (take_new)
            first_next = 1'b0;

        total_next = total_reg;
        if (push)
            total_next = total_reg + 1'b1;
        else if (finish)
            total_next = total_reg - 1'b1;

        free_next = free_reg;
        if (cpu_count_we)
            free_next = cpu_count_data;
        else if (accept && in_job.func == FUNC_ASSIGN)
            free_next = free_reg - n_w[15:0];

        pop_left_next = pop_left_reg;
        if (pop_go)
            pop_left_next = CW'(n_w);
        else if (finish)
            pop_left_next = pop_left_reg - 1'b1;

        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_job.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            free_reg      <= '0;
            pop_left_reg  <= '0;
            cnt_reg       <= '0;
            rvalid_reg    <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            free_reg      <= free_next;
            pop_left_reg  <= pop_left_next;
            cnt_reg       <= cnt_next;
            rvalid_reg    <= rd_issue;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= cnt_reg[AW-1:0];
        if (take_new)
        begin
            best_reg     <= rdata;
            best_idx_reg <= ridx_reg;
        end
        if (cmd.emit)
        begin
            out_reg      <= best_reg;
            out_last_reg <= (pop_left_reg == CW'(1));
        end
    end

    assign sts.pop_go    = pop_go;
    assign sts.pass_done = (cnt_reg == total_reg) && !rvalid_reg;
    assign sts.out_free  = !out_valid_reg || out_job.ready;
    assign sts.last_pop  = (pop_left_reg == CW'(1));

    assign out_job.valid          = out_valid_reg;
    assign out_job.out_time       = out_reg.job_time;
    assign out_job.out_id         = out_reg.job_id;
    assign out_job.out_importance = out_reg.importance;
    assign out_job.out_duration   = out_reg.duration;
    assign out_job.last_of_run    = out_last_reg;
endmodule
